>>> hdl/sparse_set_membership_engine_macros.svh
// ----------------------------------------------------------------------------
// sparse set membership engine assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_MEMBERSHIP_ENGINE_MACROS_SVH
`define SPARSE_SET_MEMBERSHIP_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion, disabled while reset is asserted
`define SSM_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ssm assertion failed");

// clocked assertion, also checked during reset
`define SSM_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("ssm assertion failed");

`else

`define SSM_ASSERT(name, clk, rst_n, prop)
`define SSM_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

>>> hdl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// shared constants, command codes and structs of the sparse set engine
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int UNIVERSE_SIZE_DEF = 256;

	localparam int CMD_W   = 3;
	localparam int ELEM_W  = 8;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 9;
	localparam int AT_W    = 8;

	localparam int S_TDATA_W = ELEM_W + POS_W;
	localparam int M_FIELD_W = 1 + COUNT_W + AT_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEL   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [ELEM_W-1:0] element;
		logic [CMD_W-1:0]  cmd;
	} ssm_cmd_t;

	typedef struct packed {
		logic               status;
		logic [AT_W-1:0]    member_at;
		logic [COUNT_W-1:0] member_count;
		logic               was_member;
	} ssm_result_t;

endpackage

>>> hdl/ssm_ram.sv
// ----------------------------------------------------------------------------
// ssm_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ssm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/ssm_core.sv
// ----------------------------------------------------------------------------
// ssm_core
// command sequencer: lookup, membership compare and two-step swap over the
// slot and element tables, plus the identity fill after reset
// ----------------------------------------------------------------------------
`include "sparse_set_membership_engine_macros.svh"

module ssm_core #(
	parameter int UNIVERSE_SIZE = ssm_pkg::UNIVERSE_SIZE_DEF,
	localparam int IDX_W = $clog2(UNIVERSE_SIZE),
	localparam int CNT_W = $clog2(UNIVERSE_SIZE + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ssm_pkg::ssm_cmd_t   req,
	output logic                ready,
	output logic                res_valid,
	input  logic                res_take,
	output ssm_pkg::ssm_result_t res,
	output logic                se_we,
	output logic [IDX_W-1:0]    se_addr,
	output logic [IDX_W-1:0]    se_wdata,
	input  logic [IDX_W-1:0]    se_rdata,
	output logic                es_we,
	output logic [IDX_W-1:0]    es_addr,
	output logic [IDX_W-1:0]    es_wdata,
	input  logic [IDX_W-1:0]    es_rdata
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_SWAP1 = 3'd3;
	localparam logic [2:0] ST_SWAP2 = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(UNIVERSE_SIZE);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(UNIVERSE_SIZE - 1);

	logic [2:0]                   state_q;
	logic [IDX_W-1:0]             clr_q;
	logic [CNT_W-1:0]             count_q;
	logic [ssm_pkg::CMD_W-1:0]    cmd_q;
	logic [ssm_pkg::ELEM_W-1:0]   elem_q;
	logic [ssm_pkg::POS_W-1:0]    pos_q;
	logic [IDX_W-1:0]             slot_q;
	logic [IDX_W-1:0]             tgt_q;
	logic [IDX_W-1:0]             other_q;
	logic                         was_q;
	logic                         status_q;
	logic [ssm_pkg::AT_W-1:0]     at_q;

	logic             elem_ok;
	logic             pos_ok;
	logic             is_member;
	logic [IDX_W-1:0] elem_idx;
	logic [IDX_W-1:0] tgt_next;
	logic             do_swap;
	logic             was_d;
	logic             status_d;
	logic [ssm_pkg::AT_W-1:0] at_d;

	assign elem_ok   = 32'(elem_q) < 32'(UNIVERSE_SIZE);
	assign pos_ok    = 32'(pos_q) < 32'(count_q);
	assign is_member = CNT_W'(es_rdata) < count_q;
	assign elem_idx  = IDX_W'(elem_q);
	assign tgt_next  = (cmd_q == ssm_pkg::CMD_ADD) ? IDX_W'(count_q)
	                                               : IDX_W'(count_q - CNT_W'(1));
	assign do_swap   = elem_ok
		&& (((cmd_q == ssm_pkg::CMD_ADD) && !is_member && (count_q < CNT_MAX))
		|| ((cmd_q == ssm_pkg::CMD_DEL) && is_member));

	// table port steering
	always_comb begin
		se_we    = 1'b0;
		se_addr  = tgt_q;
		se_wdata = elem_idx;
		es_we    = 1'b0;
		es_addr  = elem_idx;
		es_wdata = tgt_q;
		unique case (state_q)
			ST_CLR: begin
				se_we    = 1'b1;
				se_addr  = clr_q;
				se_wdata = clr_q;
				es_we    = 1'b1;
				es_addr  = clr_q;
				es_wdata = clr_q;
			end
			ST_IDLE: begin
				se_addr = IDX_W'(req.position);
				es_addr = IDX_W'(req.element);
			end
			ST_EVAL: begin
				se_addr = tgt_next;
			end
			ST_SWAP1: begin
				se_we    = 1'b1;
				se_addr  = tgt_q;
				se_wdata = elem_idx;
				es_we    = 1'b1;
				es_addr  = elem_idx;
				es_wdata = tgt_q;
			end
			ST_SWAP2: begin
				se_we    = 1'b1;
				se_addr  = slot_q;
				se_wdata = other_q;
				es_we    = 1'b1;
				es_addr  = other_q;
				es_wdata = slot_q;
			end
			default: begin
			end
		endcase
	end

	// result fields of the command under evaluation
	always_comb begin
		was_d    = 1'b0;
		status_d = 1'b0;
		at_d     = '0;
		unique case (cmd_q) inside
			ssm_pkg::CMD_ADD, ssm_pkg::CMD_DEL, ssm_pkg::CMD_QUERY: begin
				if (elem_ok) begin
					was_d = is_member;
				end else begin
					status_d = 1'b1;
				end
			end
			ssm_pkg::CMD_READ: begin
				if (pos_ok) begin
					was_d = 1'b1;
					at_d  = ssm_pkg::AT_W'(se_rdata);
				end else begin
					status_d = 1'b1;
				end
			end
			ssm_pkg::CMD_CLEAR: begin
				was_d = elem_ok && is_member;
			end
			default: begin
				status_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= do_swap ? ST_SWAP1 : ST_DONE;
					if (cmd_q == ssm_pkg::CMD_CLEAR) begin
						count_q <= '0;
					end
				end
				ST_SWAP1: begin
					state_q <= ST_SWAP2;
				end
				ST_SWAP2: begin
					count_q <= (cmd_q == ssm_pkg::CMD_ADD) ? count_q + CNT_W'(1)
					                                       : count_q - CNT_W'(1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q  <= req.cmd;
			elem_q <= req.element;
			pos_q  <= req.position;
		end
		if (state_q == ST_EVAL) begin
			slot_q   <= es_rdata;
			tgt_q    <= tgt_next;
			was_q    <= was_d;
			status_q <= status_d;
			at_q     <= at_d;
		end
		if (state_q == ST_SWAP1) begin
			other_q <= se_rdata;
		end
	end

	assign ready     = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;

	assign res.was_member   = was_q;
	assign res.member_count = ssm_pkg::COUNT_W'(count_q);
	assign res.member_at    = at_q;
	assign res.status       = status_q;

	`SSM_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_MAX)
	`SSM_ASSERT(a_start_idle, clk, arst_n, start |-> state_q == ST_IDLE)
	`SSM_ASSERT(a_swap_count, clk, arst_n, state_q == ST_SWAP2 |=> count_q != $past(count_q))
	`SSM_ASSERT(a_err_quiet, clk, arst_n, (res_valid && status_q) |-> (!was_q && at_q == '0))

endmodule

>>> hdl/sparse_set_membership_engine.sv
// ----------------------------------------------------------------------------
// sparse_set_membership_engine
// set of 0..UNIVERSE_SIZE-1 kept as a permutation and its inverse in two
// single port tables; add, delete, query, read member and clear
//
// channel  dir  tdata                                        tuser
// s_*      in   element[7:0] position[15:8]                  cmd[2:0]
// m_*      out  was_member[0] member_count[9:1]              status
//               member_at[17:10], zero pad to 24 bits
//
// query, read, clear and bad commands go from accept through the evaluate
// state to the result; add and delete that change the set also pass the swap
// states, bounded by the single port of each table (a lookup read, a partner
// read and a write of both tables in each swap state); after reset both
// tables are filled with the identity while s_tready is low
// a word waiting in the output register holds the next result in the core,
// which keeps s_tready low; s_tready is high again the cycle after that
// result is loaded into the output register
// ----------------------------------------------------------------------------
module sparse_set_membership_engine #(
	parameter int UNIVERSE_SIZE = ssm_pkg::UNIVERSE_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ssm_pkg::S_TDATA_W-1:0]   s_tdata,  // element, position
	input  logic [ssm_pkg::CMD_W-1:0]       s_tuser,  // cmd
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ssm_pkg::M_TDATA_W-1:0]   m_tdata,  // was_member, member_count, member_at
	output logic                            m_tuser   // status
);

	localparam int IDX_W = $clog2(UNIVERSE_SIZE);

	ssm_pkg::ssm_cmd_t    req;
	ssm_pkg::ssm_result_t res;

	logic             start;
	logic             ready;
	logic             res_valid;
	logic             res_take;
	logic             se_we;
	logic [IDX_W-1:0] se_addr;
	logic [IDX_W-1:0] se_wdata;
	logic [IDX_W-1:0] se_rdata;
	logic             es_we;
	logic [IDX_W-1:0] es_addr;
	logic [IDX_W-1:0] es_wdata;
	logic [IDX_W-1:0] es_rdata;

	logic                          m_tvalid_q;
	logic [ssm_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                          m_tuser_q;

	assign req.cmd      = s_tuser;
	assign req.element  = s_tdata[ssm_pkg::ELEM_W-1:0];
	assign req.position = s_tdata[ssm_pkg::S_TDATA_W-1:ssm_pkg::ELEM_W];

	assign s_tready = ready;
	assign start    = s_tvalid && ready;
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	ssm_core #(
		.UNIVERSE_SIZE(UNIVERSE_SIZE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.ready    (ready),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.se_we    (se_we),
		.se_addr  (se_addr),
		.se_wdata (se_wdata),
		.se_rdata (se_rdata),
		.es_we    (es_we),
		.es_addr  (es_addr),
		.es_wdata (es_wdata),
		.es_rdata (es_rdata)
	);

	// slot -> element
	ssm_ram #(
		.WIDTH(IDX_W),
		.DEPTH(UNIVERSE_SIZE)
	) u_slot_ram (
		.clk  (clk),
		.we   (se_we),
		.addr (se_addr),
		.wdata(se_wdata),
		.rdata(se_rdata)
	);

	// element -> slot
	ssm_ram #(
		.WIDTH(IDX_W),
		.DEPTH(UNIVERSE_SIZE)
	) u_elem_ram (
		.clk  (clk),
		.we   (es_we),
		.addr (es_addr),
		.wdata(es_wdata),
		.rdata(es_rdata)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {{ssm_pkg::M_PAD_W{1'b0}}, res.member_at, res.member_count,
			              res.was_member};
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
